### rtl/rrac_pkg.sv
package rrac_pkg;

  localparam int WORD_BITS = 64;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);

  // opcodes
  localparam logic [1:0] OP_REDUCE = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_CMP    = 2'd2;
  localparam logic [1:0] OP_NEG    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;

  // shared unit commands
  localparam logic [1:0] CMD_MUL = 2'd0;
  localparam logic [1:0] CMD_GCD = 2'd1;
  localparam logic [1:0] CMD_DIV = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] a_num;
    logic signed [63:0] a_den;
    logic signed [63:0] b_num;
    logic signed [63:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_num;
    logic [62:0]        result_den;
    logic               is_equal;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] cmd;
    word_t      opa;
    word_t      opb;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    word_t lo;
    word_t hi;
  } unit_rsp_t;

  function automatic word_t apply_sign(input word_t m, input logic neg);
    return neg ? word_t'(~m + word_t'(1)) : m;
  endfunction

  function automatic word_t mag(input word_t v);
    return apply_sign(v, v[WORD_BITS-1]);
  endfunction

  // product magnitude must fit the signed word for the given result sign
  function automatic logic mul_ovf(input unit_rsp_t r, input logic neg);
    return (r.hi != '0) || (neg ? (r.lo > W_MIN) : (r.lo > W_MAX));
  endfunction

endpackage

### rtl/rational_reduce_add_compare_unit.sv
// Rational reduce / add / compare / negate unit on signed 64-bit fractions.
//
// Input channel (in_valid/in_ready/in_data): one beat carries an opcode and
// two fractions a and b. Result channel (out_valid/out_ready/out_data): one
// beat per input beat, in order, with numerator, denominator (positive on a
// fraction result), equality flag and status (ok, overflow, division by zero).
//
// One item is worked at a time. A shared sequential unit does every
// multiply (shift-add), the binary GCD (one step a cycle) and the two
// exact divisions (restoring). Negate and early-out cases finish without
// further unit work; reduce runs the GCD and the two divisions; add runs
// three multiplies before them. in_ready is high only while the sequencer
// is idle.
//
// The finished result waits in its own register, so a new beat is taken
// while an earlier result is still stalled at out_ready; a second result
// holds in the sequencer until the output register frees.
// Reset (rst_n low, synchronous) drops any item in flight and empties the
// output register.
module rational_reduce_add_compare_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrac_pkg::out_item_t out_data
);

  localparam int W = rrac_pkg::WORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_MUL3 = 4'd4;
  localparam logic [3:0] S_RED  = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIVN = 4'd7;
  localparam logic [3:0] S_DIVD = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  rrac_pkg::word_t an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  rrac_pkg::word_t x_r, x_nxt, sn_r, sn_nxt, sd_r, sd_nxt, g_r, g_nxt, qn_r, qn_nxt;
  rrac_pkg::word_t rnum_r, rnum_nxt, rden_r, rden_nxt;
  logic            req_r, req_nxt;
  logic [1:0]      rstat_r, rstat_nxt;
  logic            out_valid_r, out_valid_nxt;
  rrac_pkg::out_item_t out_data_r, out_data_nxt;

  rrac_pkg::unit_req_t ureq;
  rrac_pkg::unit_rsp_t ursp;

  logic            neg1, neg2, neg3;
  rrac_pkg::word_t y_val;
  logic [W:0]      sum;
  logic            fin, fin_eq;
  logic [1:0]      fin_st;
  rrac_pkg::word_t fin_num, fin_den;

  rrac_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ureq),
    .rsp  (ursp)
  );

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    neg1  = an_r[W-1] ^ bd_r[W-1];
    neg2  = bn_r[W-1] ^ ad_r[W-1];
    neg3  = ad_r[W-1] ^ bd_r[W-1];
    y_val = rrac_pkg::apply_sign(ursp.lo, neg2);
    sum   = {x_r[W-1], x_r} + {y_val[W-1], y_val};

    st_nxt    = st_r;
    op_nxt    = op_r;
    an_nxt    = an_r;
    ad_nxt    = ad_r;
    bn_nxt    = bn_r;
    bd_nxt    = bd_r;
    x_nxt     = x_r;
    sn_nxt    = sn_r;
    sd_nxt    = sd_r;
    g_nxt     = g_r;
    qn_nxt    = qn_r;
    rnum_nxt  = rnum_r;
    rden_nxt  = rden_r;
    req_nxt   = req_r;
    rstat_nxt = rstat_r;

    ureq       = '0;
    ureq.cmd   = rrac_pkg::CMD_MUL;

    fin     = 1'b0;
    fin_eq  = 1'b0;
    fin_st  = rrac_pkg::ST_OK;
    fin_num = '0;
    fin_den = '0;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.opcode;
          an_nxt = in_data.a_num[W-1:0];
          ad_nxt = in_data.a_den[W-1:0];
          bn_nxt = in_data.b_num[W-1:0];
          bd_nxt = in_data.b_den[W-1:0];
          sn_nxt = in_data.a_num[W-1:0];
          sd_nxt = in_data.a_den[W-1:0];
          st_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        case (op_r)
          rrac_pkg::OP_REDUCE: st_nxt = S_RED;
          rrac_pkg::OP_ADD: begin
            ureq.start = 1'b1;
            ureq.opa   = rrac_pkg::mag(an_r);
            ureq.opb   = rrac_pkg::mag(bd_r);
            st_nxt     = S_MUL1;
          end
          rrac_pkg::OP_CMP: begin
            if (an_r == bn_r && ad_r == bd_r) begin
              fin    = 1'b1;
              fin_eq = 1'b1;
            end else begin
              ureq.start = 1'b1;
              ureq.opa   = rrac_pkg::mag(an_r);
              ureq.opb   = rrac_pkg::mag(bd_r);
              st_nxt     = S_MUL1;
            end
          end
          rrac_pkg::OP_NEG: begin
            fin = 1'b1;
            if (an_r == rrac_pkg::W_MIN || ad_r == rrac_pkg::W_MIN) begin
              // a minimum numerator wins over a zero denominator (overflow)
              fin_st = (an_r != rrac_pkg::W_MIN && ad_r == '0) ?
                       rrac_pkg::ST_ZDIV : rrac_pkg::ST_OVF;
            end else if (ad_r == '0) begin
              fin_st = rrac_pkg::ST_ZDIV;
            end else begin
              fin_num = rrac_pkg::apply_sign(an_r, !ad_r[W-1]);
              fin_den = rrac_pkg::mag(ad_r);
            end
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_MUL1: begin
        if (ursp.done) begin
          if (rrac_pkg::mul_ovf(ursp, neg1)) begin
            fin    = 1'b1;
            fin_st = rrac_pkg::ST_OVF;
          end else begin
            x_nxt      = rrac_pkg::apply_sign(ursp.lo, neg1);
            ureq.start = 1'b1;
            ureq.opa   = rrac_pkg::mag(bn_r);
            ureq.opb   = rrac_pkg::mag(ad_r);
            st_nxt     = S_MUL2;
          end
        end
      end
      S_MUL2: begin
        if (ursp.done) begin
          if (rrac_pkg::mul_ovf(ursp, neg2)) begin
            fin    = 1'b1;
            fin_st = rrac_pkg::ST_OVF;
          end else if (op_r == rrac_pkg::OP_CMP) begin
            fin    = 1'b1;
            fin_eq = (x_r == y_val);
          end else if (sum[W] != sum[W-1]) begin
            fin    = 1'b1;
            fin_st = rrac_pkg::ST_OVF;
          end else begin
            sn_nxt     = sum[W-1:0];
            ureq.start = 1'b1;
            ureq.opa   = rrac_pkg::mag(ad_r);
            ureq.opb   = rrac_pkg::mag(bd_r);
            st_nxt     = S_MUL3;
          end
        end
      end
      S_MUL3: begin
        if (ursp.done) begin
          if (rrac_pkg::mul_ovf(ursp, neg3)) begin
            fin    = 1'b1;
            fin_st = rrac_pkg::ST_OVF;
          end else begin
            sd_nxt = rrac_pkg::apply_sign(ursp.lo, neg3);
            st_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (sd_r == '0) begin
          fin    = 1'b1;
          fin_st = rrac_pkg::ST_ZDIV;
        end else if (sn_r == rrac_pkg::W_MIN || sd_r == rrac_pkg::W_MIN) begin
          fin    = 1'b1;
          fin_st = rrac_pkg::ST_OVF;
        end else begin
          ureq.start = 1'b1;
          ureq.cmd   = rrac_pkg::CMD_GCD;
          ureq.opa   = rrac_pkg::mag(sn_r);
          ureq.opb   = rrac_pkg::mag(sd_r);
          st_nxt     = S_GCD;
        end
      end
      S_GCD: begin
        if (ursp.done) begin
          g_nxt      = ursp.lo;
          ureq.start = 1'b1;
          ureq.cmd   = rrac_pkg::CMD_DIV;
          ureq.opa   = rrac_pkg::mag(sn_r);
          ureq.opb   = ursp.lo;
          st_nxt     = S_DIVN;
        end
      end
      S_DIVN: begin
        if (ursp.done) begin
          qn_nxt     = ursp.lo;
          ureq.start = 1'b1;
          ureq.cmd   = rrac_pkg::CMD_DIV;
          ureq.opa   = rrac_pkg::mag(sd_r);
          ureq.opb   = g_r;
          st_nxt     = S_DIVD;
        end
      end
      S_DIVD: begin
        if (ursp.done) begin
          fin     = 1'b1;
          fin_num = rrac_pkg::apply_sign(qn_r, sn_r[W-1] ^ sd_r[W-1]);
          fin_den = ursp.lo;
        end
      end
      S_DONE: begin
        // hold until the output register frees
        if (!out_valid_r || out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    if (fin) begin
      rnum_nxt  = fin_num;
      rden_nxt  = fin_den;
      req_nxt   = fin_eq;
      rstat_nxt = fin_st;
      st_nxt    = S_DONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.result_num = 64'($signed(rnum_r));
      out_data_nxt.result_den = 63'(rden_r);
      out_data_nxt.is_equal   = req_r;
      out_data_nxt.status     = rstat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    an_r       <= an_nxt;
    ad_r       <= ad_nxt;
    bn_r       <= bn_nxt;
    bd_r       <= bd_nxt;
    x_r        <= x_nxt;
    sn_r       <= sn_nxt;
    sd_r       <= sd_nxt;
    g_r        <= g_nxt;
    qn_r       <= qn_nxt;
    rnum_r     <= rnum_nxt;
    rden_r     <= rden_nxt;
    req_r      <= req_nxt;
    rstat_r    <= rstat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/rrac_unit.sv
module rrac_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  rrac_pkg::unit_req_t req,
  output rrac_pkg::unit_rsp_t rsp
);

  localparam int W = rrac_pkg::WORD_BITS;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_DIV  = 3'd2;
  localparam logic [2:0] U_GCOM = 3'd3;
  localparam logic [2:0] U_GU   = 3'd4;
  localparam logic [2:0] U_GV   = 3'd5;
  localparam logic [2:0] U_GFIN = 3'd6;

  logic [2:0]                 st_r, st_nxt;
  logic                       done_r, done_nxt;
  rrac_pkg::word_t            a_r, a_nxt, b_r, b_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic [rrac_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [W:0]      mul_sum, div_sh, div_diff;
  logic            div_ge, g_gt;
  rrac_pkg::word_t g_d;

  always_comb begin
    mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    div_sh   = {hi_r, lo_r[W-1]};
    div_ge   = div_sh >= {1'b0, a_r};
    div_diff = div_sh - {1'b0, a_r};
    g_gt     = a_r > b_r;
    g_d      = g_gt ? (a_r - b_r) : (b_r - a_r);

    st_nxt   = st_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;

    case (st_r)
      U_IDLE: begin
        if (req.start) begin
          case (req.cmd)
            rrac_pkg::CMD_MUL: begin
              a_nxt   = req.opa;
              lo_nxt  = req.opb;
              hi_nxt  = '0;
              cnt_nxt = rrac_pkg::CNT_W'(W);
              st_nxt  = U_MUL;
            end
            rrac_pkg::CMD_DIV: begin
              a_nxt   = req.opb;
              lo_nxt  = req.opa;
              hi_nxt  = '0;
              cnt_nxt = rrac_pkg::CNT_W'(W);
              st_nxt  = U_DIV;
            end
            rrac_pkg::CMD_GCD: begin
              a_nxt   = req.opa;
              b_nxt   = req.opb;
              cnt_nxt = '0;
              st_nxt  = U_GCOM;
            end
            default: ;
          endcase
        end
      end
      U_MUL: begin
        // add and shift right one bit
        hi_nxt  = mul_sum[W:1];
        lo_nxt  = {mul_sum[0], lo_r[W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == rrac_pkg::CNT_W'(1)) begin
          st_nxt   = U_IDLE;
          done_nxt = 1'b1;
        end
      end
      U_DIV: begin
        // restoring division, one quotient bit a cycle
        hi_nxt  = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
        lo_nxt  = {lo_r[W-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == rrac_pkg::CNT_W'(1)) begin
          st_nxt   = U_IDLE;
          done_nxt = 1'b1;
        end
      end
      U_GCOM: begin
        if (a_r == '0) begin
          lo_nxt   = b_r;
          st_nxt   = U_IDLE;
          done_nxt = 1'b1;
        end else if (b_r == '0) begin
          lo_nxt   = a_r;
          st_nxt   = U_IDLE;
          done_nxt = 1'b1;
        end else if (!(a_r[0] | b_r[0])) begin
          a_nxt   = a_r >> 1;
          b_nxt   = b_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          st_nxt = U_GU;
        end
      end
      U_GU: begin
        if (!a_r[0]) a_nxt = a_r >> 1;
        else st_nxt = U_GV;
      end
      U_GV: begin
        if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else begin
          a_nxt = g_gt ? b_r : a_r;
          b_nxt = g_d;
          if (g_d == '0) st_nxt = U_GFIN;
        end
      end
      U_GFIN: begin
        // restore the common power of two
        if (cnt_r != '0) begin
          a_nxt   = a_r << 1;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          lo_nxt   = a_r;
          st_nxt   = U_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.lo   = lo_r;
  assign rsp.hi   = hi_r;

endmodule

### rtl/rrac_chk.sv
module rrac_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rrac_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rrac_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // error results carry no fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rrac_pkg::ST_OK |->
      out_data.result_num == '0 && out_data.result_den == '0 && !out_data.is_equal)
    else $error("error result carries data");

  // an accepted beat keeps the unit busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a zero denominator on an ok result only for a compare, whose numerator is zero
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rrac_pkg::ST_OK && out_data.result_den == '0 |->
      out_data.result_num == '0)
    else $error("ok result with zero denominator and nonzero numerator");

endmodule

bind rational_reduce_add_compare_unit rrac_chk u_rrac_chk (.*);
